### design/tms_pkg.sv
// tms_pkg: widths, item and status codes and the controller/datapath
// command and status structs of the turing machine stepper
// no dependencies
package tms_pkg;

  localparam int TAPE_DEPTH  = 1024;
  localparam int MAX_RULES   = 64;
  localparam int SYMBOL_BITS = 16;

  localparam int STATE_W    = 16;
  localparam int VALUE_W    = 16;
  localparam int ADDR_IN_W  = 10;
  localparam int SLOT_IN_W  = 6;
  localparam int HEAD_OUT_W = 11;
  localparam int CFG_W      = 7;

  localparam int TAPE_AW = $clog2(TAPE_DEPTH);
  localparam int HEAD_W  = $clog2(TAPE_DEPTH + 1);
  localparam int RULE_AW = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
  localparam int RCNT_W  = $clog2(MAX_RULES + 1);
  localparam int CMP_W   = (RCNT_W > CFG_W) ? RCNT_W : CFG_W;
  localparam int ACT_W   = STATE_W + SYMBOL_BITS + 1;

  localparam logic [1:0] KIND_LOAD  = 2'd0;
  localparam logic [1:0] KIND_WRITE = 2'd1;
  localparam logic [1:0] KIND_STEP  = 2'd2;
  localparam logic [1:0] KIND_READ  = 2'd3;

  localparam logic [1:0] ST_STEPPED  = 2'd0;
  localparam logic [1:0] ST_HEAD_OOB = 2'd1;
  localparam logic [1:0] ST_NO_RULE  = 2'd2;
  localparam logic [1:0] ST_DONE     = 2'd3;

  typedef struct packed {
    logic accept;
    logic clr_step;
    logic rd_cap;
    logic match;
    logic find;
    logic exec;
    logic load_out;
  } tms_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic head_oob;
  } tms_stat_t;

endpackage

### design/turing_machine_stepper.sv
// turing_machine_stepper: single-tape turing machine, top level
// a load, write or out-of-range step goes straight to the result register, a read
// first captures the tape data, a step runs tape read, rule match, first-hit and
// action read, tape write; one item at a time, next taken once the result is registered
// reset: tape cleared by a sweep over all 1024 cells after reset, no item taken meanwhile
module turing_machine_stepper (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [tms_pkg::CFG_W-1:0]         cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [1:0]                        kind_i,
  input  logic [tms_pkg::SLOT_IN_W-1:0]     rule_index_i,
  input  logic [tms_pkg::STATE_W-1:0]       rule_state_i,
  input  logic [tms_pkg::VALUE_W-1:0]       rule_symbol_i,
  input  logic [tms_pkg::STATE_W-1:0]       rule_next_state_i,
  input  logic [tms_pkg::VALUE_W-1:0]       rule_write_symbol_i,
  input  logic                              rule_move_right_i,
  input  logic [tms_pkg::ADDR_IN_W-1:0]     tape_address_i,
  input  logic [tms_pkg::VALUE_W-1:0]       tape_value_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [1:0]                        status_o,
  output logic [tms_pkg::STATE_W-1:0]       machine_state_o,
  output logic [tms_pkg::HEAD_OUT_W-1:0]    head_position_o,
  output logic [tms_pkg::VALUE_W-1:0]       read_value_o
);
  import tms_pkg::*;

  tms_cmd_t  cmd;
  tms_stat_t stat;

  tms_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .kind_i      (kind_i),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .cmd_o       (cmd),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o)
  );

  tms_dp u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .stat_o              (stat),
    .cfg_we_i            (cfg_we_i),
    .cfg_wdata_i         (cfg_wdata_i),
    .kind_i              (kind_i),
    .rule_index_i        (rule_index_i),
    .rule_state_i        (rule_state_i),
    .rule_symbol_i       (rule_symbol_i),
    .rule_next_state_i   (rule_next_state_i),
    .rule_write_symbol_i (rule_write_symbol_i),
    .rule_move_right_i   (rule_move_right_i),
    .tape_address_i      (tape_address_i),
    .tape_value_i        (tape_value_i),
    .status_o            (status_o),
    .machine_state_o     (machine_state_o),
    .head_position_o     (head_position_o),
    .read_value_o        (read_value_o)
  );

endmodule

### design/tms_ram.sv
// tms_ram: generic single write port, single read port ram
// read data registered, no dependencies
module tms_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### design/tms_ctrl.sv
// tms_ctrl: sequencing state machine of the turing machine stepper
// depends on tms_pkg
module tms_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic [1:0]          kind_i,
  input  logic                out_stall_i,
  input  tms_pkg::tms_stat_t  stat_i,
  output tms_pkg::tms_cmd_t   cmd_o,
  output logic                in_stall_o,
  output logic                out_valid_o
);
  import tms_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_RDATA,
    S_MATCH,
    S_FIND,
    S_EXEC,
    S_OUT
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (stat_i.clr_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          unique case (kind_i)
            KIND_READ: state_d = S_RDATA;
            KIND_STEP: state_d = stat_i.head_oob ? S_OUT : S_MATCH;
            default:   state_d = S_OUT;
          endcase
        end
      end
      S_RDATA: begin
        cmd_o.rd_cap = 1'b1;
        state_d      = S_OUT;
      end
      S_MATCH: begin
        cmd_o.match = 1'b1;
        state_d     = S_FIND;
      end
      S_FIND: begin
        cmd_o.find = 1'b1;
        state_d    = S_EXEC;
      end
      S_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
    out_valid_d = cmd_o.load_out | (out_valid_q & out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

### design/tms_dp.sv
// tms_dp: datapath of the turing machine stepper: tape ram, rule table,
// parallel rule match, head and state registers, result register
// depends on tms_pkg and tms_ram
module tms_dp (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  tms_pkg::tms_cmd_t                 cmd_i,
  output tms_pkg::tms_stat_t                stat_o,
  input  logic                              cfg_we_i,
  input  logic [tms_pkg::CFG_W-1:0]         cfg_wdata_i,
  input  logic [1:0]                        kind_i,
  input  logic [tms_pkg::SLOT_IN_W-1:0]     rule_index_i,
  input  logic [tms_pkg::STATE_W-1:0]       rule_state_i,
  input  logic [tms_pkg::VALUE_W-1:0]       rule_symbol_i,
  input  logic [tms_pkg::STATE_W-1:0]       rule_next_state_i,
  input  logic [tms_pkg::VALUE_W-1:0]       rule_write_symbol_i,
  input  logic                              rule_move_right_i,
  input  logic [tms_pkg::ADDR_IN_W-1:0]     tape_address_i,
  input  logic [tms_pkg::VALUE_W-1:0]       tape_value_i,
  output logic [1:0]                        status_o,
  output logic [tms_pkg::STATE_W-1:0]       machine_state_o,
  output logic [tms_pkg::HEAD_OUT_W-1:0]    head_position_o,
  output logic [tms_pkg::VALUE_W-1:0]       read_value_o
);
  import tms_pkg::*;

  logic [RCNT_W-1:0]      rule_count_q;
  logic [STATE_W-1:0]     state_q;
  logic [HEAD_W-1:0]      head_q, head_d;
  logic [TAPE_AW-1:0]     clr_q;

  logic [STATE_W-1:0]     mstate_q [MAX_RULES];
  logic [SYMBOL_BITS-1:0] msym_q   [MAX_RULES];
  logic [MAX_RULES-1:0]   hit_q, hit_d, onehot;
  logic [RULE_AW-1:0]     idx;
  logic                   found_q;
  logic                   addr_ok_q;
  logic [1:0]             res_status_q;
  logic [SYMBOL_BITS-1:0] res_read_q;
  logic [1:0]             out_status_q;
  logic [STATE_W-1:0]     out_state_q;
  logic [HEAD_W-1:0]      out_head_q;
  logic [SYMBOL_BITS-1:0] out_read_q;

  logic                   tape_we;
  logic [TAPE_AW-1:0]     tape_waddr, tape_raddr, head_idx;
  logic [SYMBOL_BITS-1:0] tape_wdata, tape_rdata;
  logic                   act_we;
  logic [ACT_W-1:0]       act_wdata, act_rdata;
  logic [RULE_AW-1:0]     slot;
  logic                   slot_ok, addr_ok, head_oob, load_en;
  logic [STATE_W-1:0]     act_next;
  logic [SYMBOL_BITS-1:0] act_wsym;
  logic                   act_right;
  logic [CMP_W-1:0]       cfg_ext;

  assign head_oob  = (head_q >= HEAD_W'(TAPE_DEPTH));
  assign head_idx  = head_q[TAPE_AW-1:0];
  assign addr_ok   = (32'(tape_address_i) < 32'(TAPE_DEPTH));
  assign slot_ok   = (32'(rule_index_i) < 32'(MAX_RULES));
  assign slot      = RULE_AW'(rule_index_i);
  assign load_en   = cmd_i.accept && (kind_i == KIND_LOAD) && slot_ok;
  assign cfg_ext   = CMP_W'(cfg_wdata_i);

  assign act_we    = load_en;
  assign act_wdata = {rule_next_state_i, SYMBOL_BITS'(rule_write_symbol_i), rule_move_right_i};
  assign act_next  = act_rdata[ACT_W-1 -: STATE_W];
  assign act_wsym  = act_rdata[1 +: SYMBOL_BITS];
  assign act_right = act_rdata[0];

  assign stat_o.clr_last = (clr_q == TAPE_AW'(TAPE_DEPTH - 1));
  assign stat_o.head_oob = head_oob;

  always_comb begin
    tape_we    = 1'b0;
    tape_waddr = head_idx;
    tape_wdata = act_wsym;
    if (cmd_i.clr_step) begin
      tape_we    = 1'b1;
      tape_waddr = clr_q;
      tape_wdata = '0;
    end else if (cmd_i.accept && (kind_i == KIND_WRITE) && addr_ok) begin
      tape_we    = 1'b1;
      tape_waddr = TAPE_AW'(tape_address_i);
      tape_wdata = SYMBOL_BITS'(tape_value_i);
    end else if (cmd_i.exec && found_q) begin
      tape_we    = 1'b1;
    end
  end

  assign tape_raddr = (kind_i == KIND_STEP) ? head_idx : TAPE_AW'(tape_address_i);

  // parallel match against every slot below rule_count
  always_comb begin
    for (int i = 0; i < MAX_RULES; i++) begin
      hit_d[i] = (RCNT_W'(i) < rule_count_q) && (mstate_q[i] == state_q) &&
                 (msym_q[i] == tape_rdata);
    end
  end

  // lowest hit wins
  assign onehot = hit_q & (~hit_q + MAX_RULES'(1));

  always_comb begin
    idx = '0;
    for (int i = 0; i < MAX_RULES; i++) begin
      idx = idx | (onehot[i] ? RULE_AW'(i) : '0);
    end
  end

  always_comb begin
    head_d = head_q;
    if (act_right) begin
      head_d = head_q + HEAD_W'(1);
    end else if (head_q != '0) begin
      head_d = head_q - HEAD_W'(1);
    end
  end

  tms_ram #(
    .WIDTH (SYMBOL_BITS),
    .DEPTH (TAPE_DEPTH)
  ) u_tape (
    .clk_i   (clk_i),
    .we_i    (tape_we),
    .waddr_i (tape_waddr),
    .wdata_i (tape_wdata),
    .raddr_i (tape_raddr),
    .rdata_o (tape_rdata)
  );

  tms_ram #(
    .WIDTH (ACT_W),
    .DEPTH (MAX_RULES)
  ) u_act (
    .clk_i   (clk_i),
    .we_i    (act_we),
    .waddr_i (slot),
    .wdata_i (act_wdata),
    .raddr_i (idx),
    .rdata_o (act_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rule_count_q <= '0;
      state_q      <= '0;
      head_q       <= '0;
      clr_q        <= '0;
    end else begin
      if (cfg_we_i) begin
        rule_count_q <= (cfg_ext > CMP_W'(MAX_RULES)) ? RCNT_W'(MAX_RULES) : RCNT_W'(cfg_ext);
      end
      if (cmd_i.clr_step) begin
        clr_q <= clr_q + TAPE_AW'(1);
      end
      if (cmd_i.exec && found_q) begin
        state_q <= act_next;
        head_q  <= head_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_en) begin
      mstate_q[slot] <= rule_state_i;
      msym_q[slot]   <= SYMBOL_BITS'(rule_symbol_i);
    end
    if (cmd_i.accept) begin
      addr_ok_q  <= addr_ok;
      res_read_q <= '0;
      if (kind_i == KIND_STEP) begin
        res_status_q <= head_oob ? ST_HEAD_OOB : ST_NO_RULE;
      end else begin
        res_status_q <= ST_DONE;
      end
    end
    if (cmd_i.rd_cap) begin
      res_read_q <= addr_ok_q ? tape_rdata : '0;
    end
    if (cmd_i.match) begin
      hit_q <= hit_d;
    end
    if (cmd_i.find) begin
      found_q <= |hit_q;
    end
    if (cmd_i.exec) begin
      res_status_q <= found_q ? ST_STEPPED : ST_NO_RULE;
    end
    if (cmd_i.load_out) begin
      out_status_q <= res_status_q;
      out_state_q  <= state_q;
      out_head_q   <= head_q;
      out_read_q   <= res_read_q;
    end
  end

  assign status_o        = out_status_q;
  assign machine_state_o = out_state_q;
  assign head_position_o = HEAD_OUT_W'(out_head_q);
  assign read_value_o    = VALUE_W'(out_read_q);

endmodule

### design/tms_checker.sv
// tms_port_checker: port-level assertions for turing_machine_stepper, bound to
// the top level below; depends on tms_pkg
module tms_port_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_valid_i,
  input logic                              in_stall_o,
  input logic                              out_valid_o,
  input logic                              out_stall_i,
  input logic [1:0]                        status_o,
  input logic [tms_pkg::STATE_W-1:0]       machine_state_o,
  input logic [tms_pkg::HEAD_OUT_W-1:0]    head_position_o,
  input logic [tms_pkg::VALUE_W-1:0]       read_value_o
);
  import tms_pkg::*;

  // stalled word holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(status_o) &&
      $stable(machine_state_o) && $stable(head_position_o) && $stable(read_value_o)))
    else $error("stalled result word changed");

  // busy after every accepted word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("word accepted while previous one in progress");

  // tape clear sweep blocks input right after reset
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(rst_ni) |-> in_stall_o)
    else $error("input taken during tape clear");

  // only read words carry data
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o != ST_DONE)) |-> (read_value_o == '0))
    else $error("read value on step result");

  // head never passes the tape end
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (32'(head_position_o) <= 32'(TAPE_DEPTH)))
    else $error("head beyond tape end");

endmodule

bind turing_machine_stepper tms_port_checker u_tms_port_checker (.*);

### sim/tms_checker.sv
// tms_checker: watches the config, word-in and word-out ports of turing_machine_stepper,
// keeps its own tape, rule slots, state and head, predicts every result word and compares
// depends on tms_pkg
module tms_checker
  import tms_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_W-1:0]      cfg_wdata_i,
  input  logic                  in_valid_i,
  input  logic                  in_stall_i,
  input  logic [1:0]            kind_i,
  input  logic [SLOT_IN_W-1:0]  rule_index_i,
  input  logic [STATE_W-1:0]    rule_state_i,
  input  logic [VALUE_W-1:0]    rule_symbol_i,
  input  logic [STATE_W-1:0]    rule_next_state_i,
  input  logic [VALUE_W-1:0]    rule_write_symbol_i,
  input  logic                  rule_move_right_i,
  input  logic [ADDR_IN_W-1:0]  tape_address_i,
  input  logic [VALUE_W-1:0]    tape_value_i,
  input  logic                  out_valid_i,
  input  logic                  out_stall_i,
  input  logic [1:0]            status_i,
  input  logic [STATE_W-1:0]    machine_state_i,
  input  logic [HEAD_OUT_W-1:0] head_position_i,
  input  logic [VALUE_W-1:0]    read_value_i,
  output int                    mismatches_o,
  output int                    pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [1:0]            status;
    logic [STATE_W-1:0]    state;
    logic [HEAD_OUT_W-1:0] head;
    logic [VALUE_W-1:0]    rd;
  } tm_result_t;

  logic [SYMBOL_BITS-1:0] tape_m      [TAPE_DEPTH];
  logic [STATE_W-1:0]     rule_state_m [MAX_RULES];
  logic [SYMBOL_BITS-1:0] rule_sym_m   [MAX_RULES];
  logic [STATE_W-1:0]     rule_next_m  [MAX_RULES];
  logic [SYMBOL_BITS-1:0] rule_wsym_m  [MAX_RULES];
  logic                   rule_right_m [MAX_RULES];
  logic [RCNT_W-1:0]      active_rules;
  logic [STATE_W-1:0]     cur_state;
  logic [HEAD_W-1:0]      head_m;

  tm_result_t expected_q[$];
  int mismatches = 0;
  int words_checked = 0;

  task automatic report_failure(input string msg);
    $display("[%0t] tms_checker word %0d: %s", $time, words_checked, msg);
    mismatches++;
  endtask

  // applies the accepted word to the machine copy and returns the result it must give
  function automatic tm_result_t apply_machine_word();
    tm_result_t r;
    logic [SYMBOL_BITS-1:0] sym;
    int hit;
    r = '0;
    r.status = ST_DONE;
    case (kind_i)
      KIND_LOAD: begin
        rule_state_m[rule_index_i] = rule_state_i;
        rule_sym_m[rule_index_i]   = rule_symbol_i[SYMBOL_BITS-1:0];
        rule_next_m[rule_index_i]  = rule_next_state_i;
        rule_wsym_m[rule_index_i]  = rule_write_symbol_i[SYMBOL_BITS-1:0];
        rule_right_m[rule_index_i] = rule_move_right_i;
      end
      KIND_WRITE: tape_m[tape_address_i] = tape_value_i[SYMBOL_BITS-1:0];
      KIND_READ:  r.rd = tape_m[tape_address_i];
      KIND_STEP: begin
        if (head_m >= TAPE_DEPTH) begin
          r.status = ST_HEAD_OOB;
        end else begin
          sym = tape_m[head_m[TAPE_AW-1:0]];
          hit = -1;
          for (int i = 0; i < MAX_RULES; i++) begin
            if (hit < 0 && i < active_rules && rule_state_m[i] == cur_state &&
                rule_sym_m[i] == sym) begin
              hit = i;
            end
          end
          if (hit < 0) begin
            r.status = ST_NO_RULE;
          end else begin
            cur_state = rule_next_m[hit];
            tape_m[head_m[TAPE_AW-1:0]] = rule_wsym_m[hit];
            if (rule_right_m[hit]) head_m = head_m + 1'b1;
            else if (head_m != 0) head_m = head_m - 1'b1;
            r.status = ST_STEPPED;
          end
        end
      end
    endcase
    r.state = cur_state;
    r.head  = head_m;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    tm_result_t want;
    if (!rst_ni) begin
      for (int a = 0; a < TAPE_DEPTH; a++) tape_m[a] = '0;
      for (int s = 0; s < MAX_RULES; s++) begin
        rule_state_m[s] = '0;
        rule_sym_m[s]   = '0;
        rule_next_m[s]  = '0;
        rule_wsym_m[s]  = '0;
        rule_right_m[s] = 1'b0;
      end
      active_rules = '0;
      cur_state    = '0;
      head_m       = '0;
      expected_q.delete();
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_q.size() == 0) begin
          report_failure($sformatf("result word with nothing predicted, status %0d", status_i));
        end else begin
          want = expected_q.pop_front();
          if (status_i !== want.status)
            report_failure($sformatf("status got %0d want %0d", status_i, want.status));
          if (machine_state_i !== want.state)
            report_failure($sformatf("state got %h want %h", machine_state_i, want.state));
          if (head_position_i !== want.head)
            report_failure($sformatf("head got %0d want %0d", head_position_i, want.head));
          if (read_value_i !== want.rd)
            report_failure($sformatf("read value got %h want %h", read_value_i, want.rd));
        end
        words_checked++;
      end
      if (cfg_we_i)
        active_rules = (cfg_wdata_i > MAX_RULES) ? RCNT_W'(MAX_RULES) : RCNT_W'(cfg_wdata_i);
      if (in_valid_i && !in_stall_i) expected_q.push_back(apply_machine_word());
    end
    mismatches_o <= mismatches;
    pending_o    <= expected_q.size();
  end

endmodule

### sim/tb_turing_machine_stepper.sv
// tb_turing_machine_stepper: drives rule loads, tape accesses and steps into
// turing_machine_stepper with random gaps and stalls; tms_checker predicts and compares
// depends on tms_pkg, turing_machine_stepper and tms_checker
module tb_turing_machine_stepper;
  timeunit 1ns;
  timeprecision 1ps;
  import tms_pkg::*;

  typedef struct packed {
    logic [1:0]           kind;
    logic [SLOT_IN_W-1:0] slot;
    logic [STATE_W-1:0]   mstate;
    logic [VALUE_W-1:0]   msym;
    logic [STATE_W-1:0]   nstate;
    logic [VALUE_W-1:0]   wsym;
    logic                 right;
    logic [ADDR_IN_W-1:0] addr;
    logic [VALUE_W-1:0]   value;
  } tm_word_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_W-1:0]      cfg_wdata_i = '0;
  logic                  in_valid_i = 1'b0;
  logic                  in_stall_o;
  logic [1:0]            kind_i = KIND_READ;
  logic [SLOT_IN_W-1:0]  rule_index_i = '0;
  logic [STATE_W-1:0]    rule_state_i = '0;
  logic [VALUE_W-1:0]    rule_symbol_i = '0;
  logic [STATE_W-1:0]    rule_next_state_i = '0;
  logic [VALUE_W-1:0]    rule_write_symbol_i = '0;
  logic                  rule_move_right_i = 1'b0;
  logic [ADDR_IN_W-1:0]  tape_address_i = '0;
  logic [VALUE_W-1:0]    tape_value_i = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  logic [1:0]            status_o;
  logic [STATE_W-1:0]    machine_state_o;
  logic [HEAD_OUT_W-1:0] head_position_o;
  logic [VALUE_W-1:0]    read_value_o;

  int mismatches;
  int pending;

  bit gaps_on = 1'b1;
  bit filling = 1'b0;
  bit slot_loaded [MAX_RULES];
  int words_sent = 0;
  int results_seen = 0;
  int kind_tally [4] = '{default: 0};
  int status_tally [4] = '{default: 0};
  int stall_left = 0;
  logic [1:0]            last_status = ST_DONE;
  logic [STATE_W-1:0]    last_state = '0;
  logic [HEAD_OUT_W-1:0] last_head = '0;

  always #2 clk_i = ~clk_i;

  turing_machine_stepper u_dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_we_i            (cfg_we_i),
    .cfg_wdata_i         (cfg_wdata_i),
    .in_valid_i          (in_valid_i),
    .in_stall_o          (in_stall_o),
    .kind_i              (kind_i),
    .rule_index_i        (rule_index_i),
    .rule_state_i        (rule_state_i),
    .rule_symbol_i       (rule_symbol_i),
    .rule_next_state_i   (rule_next_state_i),
    .rule_write_symbol_i (rule_write_symbol_i),
    .rule_move_right_i   (rule_move_right_i),
    .tape_address_i      (tape_address_i),
    .tape_value_i        (tape_value_i),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .status_o            (status_o),
    .machine_state_o     (machine_state_o),
    .head_position_o     (head_position_o),
    .read_value_o        (read_value_o)
  );

  tms_checker u_checker (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_we_i            (cfg_we_i),
    .cfg_wdata_i         (cfg_wdata_i),
    .in_valid_i          (in_valid_i),
    .in_stall_i          (in_stall_o),
    .kind_i              (kind_i),
    .rule_index_i        (rule_index_i),
    .rule_state_i        (rule_state_i),
    .rule_symbol_i       (rule_symbol_i),
    .rule_next_state_i   (rule_next_state_i),
    .rule_write_symbol_i (rule_write_symbol_i),
    .rule_move_right_i   (rule_move_right_i),
    .tape_address_i      (tape_address_i),
    .tape_value_i        (tape_value_i),
    .out_valid_i         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .status_i            (status_o),
    .machine_state_i     (machine_state_o),
    .head_position_i     (head_position_o),
    .read_value_i        (read_value_o),
    .mismatches_o        (mismatches),
    .pending_o           (pending)
  );

  always @(posedge clk_i) begin
    if (out_valid_o && !out_stall_i) begin
      results_seen <= results_seen + 1;
      last_status  <= status_o;
      last_state   <= machine_state_o;
      last_head    <= head_position_o;
      status_tally[status_o] <= status_tally[status_o] + 1;
    end
  end

  // receiver stalls in bursts of random length
  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if (gaps_on && $urandom_range(0, 5) == 0) begin
      out_stall_i <= 1'b1;
      stall_left  <= $urandom_range(0, 11);
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  function automatic tm_word_t noise_word();
    tm_word_t w;
    w.kind   = 2'($urandom_range(0, 3));
    w.slot   = SLOT_IN_W'($urandom);
    w.mstate = STATE_W'($urandom);
    w.msym   = VALUE_W'($urandom);
    w.nstate = STATE_W'($urandom);
    w.wsym   = VALUE_W'($urandom);
    w.right  = 1'($urandom_range(0, 1));
    w.addr   = ADDR_IN_W'($urandom);
    w.value  = VALUE_W'($urandom);
    return w;
  endfunction

  function automatic tm_word_t load_word(input logic [SLOT_IN_W-1:0] slot,
                                         input logic [STATE_W-1:0] ms,
                                         input logic [VALUE_W-1:0] msym,
                                         input logic [STATE_W-1:0] ns,
                                         input logic [VALUE_W-1:0] ws,
                                         input logic right);
    tm_word_t w;
    w = noise_word();
    w.kind   = KIND_LOAD;
    w.slot   = slot;
    w.mstate = ms;
    w.msym   = msym;
    w.nstate = ns;
    w.wsym   = ws;
    w.right  = right;
    return w;
  endfunction

  function automatic tm_word_t tape_write_word(input logic [ADDR_IN_W-1:0] addr,
                                               input logic [VALUE_W-1:0] value);
    tm_word_t w;
    w = noise_word();
    w.kind  = KIND_WRITE;
    w.addr  = addr;
    w.value = value;
    return w;
  endfunction

  function automatic tm_word_t tape_read_word(input logic [ADDR_IN_W-1:0] addr);
    tm_word_t w;
    w = noise_word();
    w.kind = KIND_READ;
    w.addr = addr;
    return w;
  endfunction

  function automatic tm_word_t step_word();
    tm_word_t w;
    w = noise_word();
    w.kind = KIND_STEP;
    return w;
  endfunction

  function automatic int loaded_prefix();
    int n;
    n = 0;
    while (n < MAX_RULES && slot_loaded[n]) n++;
    return n;
  endfunction

  function automatic logic [ADDR_IN_W-1:0] near_head();
    int a;
    a = int'($urandom_range(0, 16)) - 8 + int'(last_head);
    if (a < 0) a = 0;
    if (a > TAPE_DEPTH - 1) a = TAPE_DEPTH - 1;
    return a[ADDR_IN_W-1:0];
  endfunction

  // small state and symbol alphabets keep the machine moving, some words full range
  function automatic tm_word_t random_word(input int load_pct);
    tm_word_t w;
    int pick;
    w = noise_word();
    pick = $urandom_range(0, 99);
    if (pick < load_pct) begin
      w.kind = KIND_LOAD;
      if (filling && loaded_prefix() < MAX_RULES) w.slot = SLOT_IN_W'(loaded_prefix());
      if ($urandom_range(0, 6) != 0) begin
        w.mstate = ($urandom_range(0, 4) == 0) ? last_state : STATE_W'($urandom_range(0, 3));
        w.msym   = VALUE_W'($urandom_range(0, 3));
        w.nstate = STATE_W'($urandom_range(0, 3));
        w.wsym   = VALUE_W'($urandom_range(0, 3));
        w.right  = $urandom_range(0, 9) < 6;
      end
    end else if (pick < load_pct + 15) begin
      w.kind = KIND_WRITE;
      if ($urandom_range(0, 1) == 0) w.addr = near_head();
      if ($urandom_range(0, 4) != 0) w.value = VALUE_W'($urandom_range(0, 3));
    end else if (pick < load_pct + 30) begin
      w.kind = KIND_READ;
      if ($urandom_range(0, 1) == 0) w.addr = near_head();
    end else begin
      w.kind = KIND_STEP;
    end
    return w;
  endfunction

  task automatic send_word(input tm_word_t w);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      if (in_valid_i) in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
    kind_i              <= w.kind;
    rule_index_i        <= w.slot;
    rule_state_i        <= w.mstate;
    rule_symbol_i       <= w.msym;
    rule_next_state_i   <= w.nstate;
    rule_write_symbol_i <= w.wsym;
    rule_move_right_i   <= w.right;
    tape_address_i      <= w.addr;
    tape_value_i        <= w.value;
    in_valid_i          <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    words_sent++;
    kind_tally[w.kind]++;
    if (w.kind == KIND_LOAD) slot_loaded[w.slot] = 1'b1;
  endtask

  task automatic wait_idle();
    if (in_valid_i) in_valid_i <= 1'b0;
    while (results_seen != words_sent) @(posedge clk_i);
  endtask

  task automatic write_rule_count(input logic [CFG_W-1:0] count);
    cfg_wdata_i <= count;
    cfg_we_i    <= 1'b1;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // count must never reach past the loaded slots
  task automatic run_phase(input logic [CFG_W-1:0] count, input int words,
                           input int load_pct, input bit gaps);
    int sent;
    wait_idle();
    write_rule_count(count);
    gaps_on <= gaps;
    sent = 0;
    while (sent < words || (filling && loaded_prefix() < MAX_RULES)) begin
      send_word(random_word(load_pct));
      sent++;
    end
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    send_word(tape_write_word(ADDR_IN_W'(TAPE_DEPTH - 1), '1));
    send_word(tape_read_word(ADDR_IN_W'(TAPE_DEPTH - 1)));
    send_word(tape_read_word('0));
    send_word(step_word());
    send_word(load_word(SLOT_IN_W'(MAX_RULES - 1), '1, '1, '1, '1, 1'b1));
    send_word(load_word(6'd0, 16'd0, 16'd0, 16'd1, 16'd2, 1'b0));
    send_word(load_word(6'd1, 16'd0, 16'd0, 16'd7, 16'd7, 1'b1));
    send_word(load_word(6'd2, 16'd1, 16'd2, '1, 16'd0, 1'b1));
    send_word(load_word(6'd3, '1, 16'd0, 16'd0, '1, 1'b1));
    wait_idle();
    write_rule_count(CFG_W'(4));
    // left move at cell 0, shadowed duplicate, all-ones state, then a miss
    repeat (5) send_word(step_word());
    send_word(tape_read_word(10'd1));
    send_word(tape_read_word(10'd0));

    filling = 1'b1;
    run_phase(CFG_W'(loaded_prefix()), 20, 80, 1'b1);
    filling = 1'b0;
    run_phase(CFG_W'(MAX_RULES), 25, 20, 1'b0);
    run_phase('1, 25, 20, 1'b1);
    run_phase('0, 10, 20, 1'b1);
    run_phase(CFG_W'(1), 15, 20, 1'b0);
    run_phase(CFG_W'($urandom_range(0, 127)), 25, 20, 1'b1);

    // march the head off the tape end, clearing cells no rule can read
    wait_idle();
    gaps_on <= 1'b0;
    for (int k = 0; k < 4; k++) begin
      send_word(load_word(SLOT_IN_W'(k), last_state, VALUE_W'(k), last_state, VALUE_W'(k),
                          1'b1));
    end
    wait_idle();
    write_rule_count(CFG_W'(4));
    while (last_head < TAPE_DEPTH) begin
      send_word(step_word());
      wait_idle();
      if (last_status == ST_NO_RULE) begin
        send_word(tape_write_word(last_head[ADDR_IN_W-1:0], '0));
        wait_idle();
      end
    end
    run_phase(CFG_W'(100), 16, 20, 1'b0);

    wait_idle();
    repeat (10) @(posedge clk_i);
    $display("%0d words: %0d rule loads, %0d tape writes, %0d tape reads, %0d steps",
             words_sent, kind_tally[KIND_LOAD], kind_tally[KIND_WRITE],
             kind_tally[KIND_READ], kind_tally[KIND_STEP]);
    $display("steps: %0d moved the head, %0d stopped at the tape end, %0d found no rule",
             status_tally[ST_STEPPED], status_tally[ST_HEAD_OOB], status_tally[ST_NO_RULE]);
    if (mismatches == 0 && pending == 0) begin
      $display("tb_turing_machine_stepper passed");
    end else begin
      $display("tb_turing_machine_stepper failed");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("tb_turing_machine_stepper failed");
    $finish;
  end

endmodule
